// File: src/lphs_pkg.sv
// Shared types and constants for the linear probing hash set.
package lphs_pkg;

    // Table geometry; SLOTS must be a power of two so the home slot is the key's low bits
    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 64;
    localparam int IDX_W   = 8;
    localparam int KC_W    = 9;
    localparam int ENTRY_W = KEY_W + 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_FULL  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RESP
    } state_t;

    typedef struct packed {
        op_t              kind;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             success;
        logic             table_full;
        logic [IDX_W-1:0] slot_index;
        logic [KC_W-1:0]  key_count;
    } rsp_t;

    // One slot as kept in the table memory
    typedef struct packed {
        mark_t            mark;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

// File: src/linear_probe_hash_set.sv
// Linear probing hash set of 64-bit keys with tombstones, one memory holds all slots.
// Sequence: a lookup, insert or delete reads its slots one per cycle in the probe state,
// then hands the result beat to the output register; clear and a lookup or delete on an
// empty set skip the probe. A new request is taken only once the last result has left the
// sequencer, which holds it while the output register is full and its beat is not taken.
// Reset: all slots empty, key count zero, no result pending; usable right after reset.
module linear_probe_hash_set
    import lphs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    lphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    lphs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: take a result when empty or when the held beat leaves
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: src/lphs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/lphs_ctrl.sv
// Probe sequencer: walks the table memory, tracks slot liveness and the key count.
module lphs_ctrl
    import lphs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output rsp_t              res,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_addr,
    output entry_t            wr_data,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_addr,
    input  entry_t            rd_data
);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;
    logic [SLOT_W-1:0]  steps_reg, steps_next;
    logic               free_found_reg, free_found_next;
    logic [SLOT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOTS-1:0]   live_reg, live_next;
    rsp_t               res_reg, res_next;

    mark_t              cur_mark;
    logic               is_full;
    logic               is_empty;
    logic               hit;
    logic               last;
    logic               stop;
    logic               free_any;
    logic [SLOT_W-1:0]  free_now;
    logic [SLOT_W-1:0]  addr_inc;

    // Classify the slot whose data just came back from memory
    always_comb
    begin
        cur_mark = live_reg[addr_reg] ? rd_data.mark : MARK_EMPTY;
        is_full  = (cur_mark == MARK_FULL);
        is_empty = (cur_mark == MARK_EMPTY);
        hit      = is_full && (rd_data.key == key_reg);
        last     = (steps_reg == SLOT_W'(SLOTS - 1));
        stop     = hit || is_empty || last;
        free_any = free_found_reg || !is_full;
        free_now = free_found_reg ? free_reg : addr_reg;
        addr_inc = (addr_reg == SLOT_W'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        steps_next      = steps_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        live_next       = live_reg;
        res_next        = res_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_inc;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '{mark: MARK_FULL, key: key_reg};

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next         = req.kind;
                    key_next        = req.key;
                    addr_next       = req.key[SLOT_W-1:0];
                    steps_next      = '0;
                    free_found_next = 1'b0;
                    rd_addr         = req.key[SLOT_W-1:0];
                    res_next        = '{success: 1'b0, table_full: 1'b0,
                                        slot_index: '0, key_count: '0};
                    case (req.kind)
                        OP_CLEAR:
                        begin
                            // Drop every slot at once and zero the count
                            live_next        = '0;
                            count_next       = '0;
                            res_next.success = 1'b1;
                            state_next       = ST_RESP;
                        end
                        OP_INSERT:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_PROBE;
                        end
                        default:
                        begin
                            // Lookup and delete miss at once on an empty set
                            if (count_reg == '0)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_PROBE;
                            end
                        end
                    endcase
                end
            end

            ST_PROBE:
            begin
                if (!stop)
                begin
                    // Advance to the next slot, remember the first free one
                    rd_en      = 1'b1;
                    addr_next  = addr_inc;
                    steps_next = steps_reg + 1'b1;
                    if (!is_full && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = addr_reg;
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                    if (hit)
                    begin
                        res_next.slot_index = IDX_W'(addr_reg);
                        res_next.success    = (op_reg != OP_INSERT);
                        if (op_reg == OP_DELETE)
                        begin
                            // Leave a tombstone behind
                            wr_en        = 1'b1;
                            wr_addr      = addr_reg;
                            wr_data.mark = MARK_TOMB;
                            count_next   = count_reg - 1'b1;
                        end
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        if (free_any)
                        begin
                            wr_en               = 1'b1;
                            wr_addr             = free_now;
                            live_next[free_now] = 1'b1;
                            count_next          = count_reg + 1'b1;
                            res_next.success    = 1'b1;
                            res_next.slot_index = IDX_W'(free_now);
                        end
                        else
                        begin
                            res_next.table_full = 1'b1;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Report the count as it stands after the operation
        if (state_reg != ST_RESP)
        begin
            res_next.key_count = KC_W'(count_next);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            live_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            live_reg       <= live_next;
            free_found_reg <= free_found_next;
        end
    end

    // Operation payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        addr_reg  <= addr_next;
        steps_reg <= steps_next;
        free_reg  <= free_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule
